// ----- design/head_tail_frame_finder_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the head/tail frame finder.
// Each macro expects a clock named clk and a reset named arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef HEAD_TAIL_FRAME_FINDER_ASSERT_SVH
`define HEAD_TAIL_FRAME_FINDER_ASSERT_SVH

// Same-cycle implication.
`define HTFF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("head_tail_frame_finder: same-cycle check failed");

// Next-cycle implication.
`define HTFF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("head_tail_frame_finder: next-cycle check failed");

`endif

// ----- design/htff_pkg.sv -----
// ---------------------------------------------------------------------------
// htff_pkg
// Shared constants, types and the window compare for the frame finder.
// ---------------------------------------------------------------------------
package htff_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_FRAME   = 1024;

	localparam int WIN_W = 8 * MAX_PATTERN;
	localparam int PLEN_W = $clog2(MAX_PATTERN + 1) < 4 ? 4 : $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = $clog2(MAX_FRAME);
	localparam int LEN_W = IDX_W + 1;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HEAD_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_LENGTH  = 2'd3;

	typedef enum logic [1:0] {
		PH_HEAD = 2'd0,
		PH_TAIL = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	// Active configuration, lengths already clamped to 1..MAX_PATTERN.
	typedef struct packed {
		logic [WIN_W-1:0]  head_pattern;
		logic [PLEN_W-1:0] head_bytes;
		logic [WIN_W-1:0]  tail_pattern;
		logic [PLEN_W-1:0] tail_bytes;
	} cfg_t;

	// Result word as it leaves the core.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_start;
		logic [LEN_W-1:0] match_length;
	} result_t;

	function automatic logic [PLEN_W-1:0] eff_len(input logic [3:0] n);
		logic [PLEN_W-1:0] r;
		if (n == 4'd0) begin
			r = PLEN_W'(1);
		end else if (32'(n) > MAX_PATTERN) begin
			r = PLEN_W'(MAX_PATTERN);
		end else begin
			r = PLEN_W'(n);
		end
		return r;
	endfunction

	// The newest n bytes sit in the top lanes of the window, oldest of them
	// compared against pattern byte 0.
	function automatic logic window_match(input logic [WIN_W-1:0] window,
			input logic [WIN_W-1:0] pattern, input logic [PLEN_W-1:0] n);
		logic ok;
		int   lane;
		ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			lane = MAX_PATTERN - int'(n) + k;
			if (k < int'(n) && lane >= 0 && lane < MAX_PATTERN) begin
				if (window[8*lane +: 8] != pattern[8*k +: 8]) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

endpackage

// ----- design/htff_cfg.sv -----
// ---------------------------------------------------------------------------
// htff_cfg
// Configuration registers with clamped pattern lengths.
// ---------------------------------------------------------------------------
module htff_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [htff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [htff_pkg::CFG_DATA_W-1:0]     cfg_data,
	output htff_pkg::cfg_t                      cfg
);

	logic [htff_pkg::WIN_W-1:0] head_pattern_q;
	logic [3:0]                 head_length_q;
	logic [htff_pkg::WIN_W-1:0] tail_pattern_q;
	logic [3:0]                 tail_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pattern_q <= '0;
			head_length_q  <= 4'd1;
			tail_pattern_q <= '0;
			tail_length_q  <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				htff_pkg::REG_HEAD_PATTERN: head_pattern_q <= cfg_data[htff_pkg::WIN_W-1:0];
				htff_pkg::REG_HEAD_LENGTH:  head_length_q  <= cfg_data[3:0];
				htff_pkg::REG_TAIL_PATTERN: tail_pattern_q <= cfg_data[htff_pkg::WIN_W-1:0];
				htff_pkg::REG_TAIL_LENGTH:  tail_length_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.head_pattern = head_pattern_q;
		cfg.head_bytes   = htff_pkg::eff_len(head_length_q);
		cfg.tail_pattern = tail_pattern_q;
		cfg.tail_bytes   = htff_pkg::eff_len(tail_length_q);
	end

endmodule

// ----- design/htff_core.sv -----
// ---------------------------------------------------------------------------
// htff_core
// Input register, frame search state and result register.
// ---------------------------------------------------------------------------
module htff_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  htff_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	output logic                   res_valid,
	input  logic                   res_ready,
	output htff_pkg::result_t      res
);

	localparam logic [htff_pkg::IDX_W-1:0] IDX_TOP = htff_pkg::IDX_W'(htff_pkg::MAX_FRAME - 1);
	localparam logic [htff_pkg::LEN_W-1:0] LEN_TOP = htff_pkg::LEN_W'(htff_pkg::MAX_FRAME);

	logic                         vld_s1;
	logic [7:0]                   byte_s1;
	logic                         last_s1;

	logic                         vld_s2;
	htff_pkg::result_t            res_s2;

	logic [htff_pkg::WIN_W-1:0]   window_q;
	logic [htff_pkg::IDX_W-1:0]   index_q;
	htff_pkg::phase_t             phase_q;
	logic [htff_pkg::IDX_W-1:0]   head_start_q;
	logic [htff_pkg::LEN_W-1:0]   after_head_q;

	logic                         advance;
	logic                         work;
	logic [htff_pkg::WIN_W-1:0]   window_d;
	logic [htff_pkg::IDX_W-1:0]   index_d;
	htff_pkg::phase_t             phase_d;
	logic [htff_pkg::IDX_W-1:0]   head_start_d;
	logic [htff_pkg::LEN_W-1:0]   after_head_d;
	logic [htff_pkg::LEN_W-1:0]   index_p1;
	logic [htff_pkg::LEN_W:0]     len_sum;
	logic                         hit;
	logic                         emit;
	htff_pkg::result_t            res_d;

	// The whole pipe moves when the result register is free or being drained.
	assign advance  = !vld_s2 || res_ready;
	assign in_ready = !vld_s1 || advance;
	assign work     = vld_s1 && advance;

	always_comb begin
		window_d     = {byte_s1, window_q[htff_pkg::WIN_W-1:8]};
		index_d      = (index_q < IDX_TOP) ? index_q + 1'b1 : index_q;
		phase_d      = phase_q;
		head_start_d = head_start_q;
		after_head_d = after_head_q;
		index_p1     = {1'b0, index_q} + 1'b1;
		len_sum      = '0;
		hit          = 1'b0;
		res_d        = '0;

		case (phase_q)
			htff_pkg::PH_HEAD: begin
				if (index_p1 >= htff_pkg::LEN_W'(cfg.head_bytes) &&
						htff_pkg::window_match(window_d, cfg.head_pattern, cfg.head_bytes)) begin
					head_start_d = htff_pkg::IDX_W'(index_p1 - htff_pkg::LEN_W'(cfg.head_bytes));
					after_head_d = '0;
					phase_d      = htff_pkg::PH_TAIL;
				end
			end
			htff_pkg::PH_TAIL: begin
				if (after_head_q < LEN_TOP) begin
					after_head_d = after_head_q + 1'b1;
				end
				if (after_head_d >= htff_pkg::LEN_W'(cfg.tail_bytes) &&
						htff_pkg::window_match(window_d, cfg.tail_pattern, cfg.tail_bytes)) begin
					hit     = 1'b1;
					phase_d = htff_pkg::PH_DONE;
				end
			end
			default: ;
		endcase

		len_sum = {1'b0, after_head_d} + (htff_pkg::LEN_W + 1)'(cfg.head_bytes);
		if (hit) begin
			res_d.found        = 1'b1;
			res_d.match_start  = head_start_q;
			res_d.match_length = (len_sum > {1'b0, LEN_TOP}) ? LEN_TOP
				: len_sum[htff_pkg::LEN_W-1:0];
		end

		// A frame that ends without a match still reports once, as not found.
		emit = hit || (last_s1 && phase_d != htff_pkg::PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			index_q      <= '0;
			phase_q      <= htff_pkg::PH_HEAD;
			head_start_q <= '0;
			after_head_q <= '0;
		end else if (work) begin
			if (last_s1) begin
				window_q     <= '0;
				index_q      <= '0;
				phase_q      <= htff_pkg::PH_HEAD;
				head_start_q <= '0;
				after_head_q <= '0;
			end else begin
				window_q     <= window_d;
				index_q      <= index_d;
				phase_q      <= phase_d;
				head_start_q <= head_start_d;
				after_head_q <= after_head_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= work && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

// ----- design/head_tail_frame_finder.sv -----
// ---------------------------------------------------------------------------
// head_tail_frame_finder
// Finds a head pattern and the first following tail pattern in a frame.
// ---------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on the s_ stream, one byte per word in s_tdata[7:0],
//   with s_tlast on the last byte of the frame. Each frame gives exactly one
//   result word on the m_ stream: m_tuser is the found flag, m_tdata holds
//   the head start index and the length from head start through tail end
//   (both zero when nothing was found). A result leaves as soon as the tail
//   completes; a frame without a match reports on its last byte.
//   Patterns and lengths are written through cfg_we/cfg_index/cfg_data
//   between frames.
//   A byte passes the input register and then the result register on its
//   way to the result word. One byte is taken every cycle unless a result
//   waits; the search state updates from a single shift-window compare.
//   When the receiver holds m_tready low, the result register holds its
//   word and the input register stalls behind it after at most one more byte.
//   Reset clears the search state, sets both lengths to one and both
//   patterns to zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "head_tail_frame_finder_assert.svh"

module head_tail_frame_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [htff_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [htff_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] in_byte
	input  logic                                s_tlast,   // frame_end
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,   // [9:0] match_start, [20:10] match_length
	output logic                                m_tuser    // found
);

	htff_pkg::cfg_t    cfg;
	htff_pkg::result_t res;

	htff_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	htff_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {3'b000, res.match_length, res.match_start};
	assign m_tuser = res.found;

	// A not-found word carries zero index and length.
	`HTFF_ASSERT_NOW(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == 24'd0)
	// A found match spans at least one head byte and one tail byte.
	`HTFF_ASSERT_NOW(a_found_len, m_tvalid && m_tuser, m_tdata[20:10] >= 11'd2)
	// The input side only stalls behind a waiting result.
	`HTFF_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Head/tail frame finder testbench
// Streams frames of bytes into the finder and checks each result word
// against a cycle-free predictor of the head and tail search. Frames are
// mostly well-formed (head, then tail, inside random bytes), with frames
// missing the tail, frames with the tail ahead of the head, plain noise and
// one frame longer than the index range. Pattern lengths sweep their
// extremes, including the out-of-range codes, and both sides of the stream
// idle and stall at random, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SEG_BYTES   = 24;
	localparam int HOLD_CYCLES = 300;

	// Scoreboard: predicts the result word of every frame and checks the
	// words that leave the block against those predictions, in order.
	class frame_search_sb;
		logic [63:0]       head_pat;
		logic [63:0]       tail_pat;
		logic [3:0]        head_len_reg;
		logic [3:0]        tail_len_reg;
		logic [63:0]       window;
		int unsigned       byte_pos;
		int unsigned       head_start;
		int unsigned       after_head;
		htff_pkg::phase_t  phase;
		htff_pkg::result_t expected_q[$];
		int                errors;

		function new();
			head_pat = '0;
			tail_pat = '0;
			head_len_reg = 4'd1;
			tail_len_reg = 4'd1;
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			window = '0;
			byte_pos = 0;
			phase = htff_pkg::PH_HEAD;
			head_start = 0;
			after_head = 0;
		endfunction

		function void set_config(logic [63:0] hp, logic [3:0] hl, logic [63:0] tp,
				logic [3:0] tl);
			head_pat = hp;
			head_len_reg = hl;
			tail_pat = tp;
			tail_len_reg = tl;
		endfunction

		function int unsigned usable_len(logic [3:0] n);
			if (n == 4'd0) begin
				return 1;
			end else if (n > htff_pkg::MAX_PATTERN) begin
				return htff_pkg::MAX_PATTERN;
			end
			return n;
		endfunction

		// The newest n bytes sit in the top lanes of the window.
		function bit window_hit(logic [63:0] pattern, int unsigned n);
			logic [63:0] recent;
			logic [63:0] mask;
			recent = window >> (8 * (8 - n));
			mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
			return (recent & mask) == (pattern & mask);
		endfunction

		function void note_byte(logic [7:0] value, logic is_last);
			int unsigned       hl;
			int unsigned       tl;
			int unsigned       span;
			htff_pkg::result_t r;
			bit                hit;
			hl = usable_len(head_len_reg);
			tl = usable_len(tail_len_reg);
			hit = 1'b0;
			r = '0;
			window = {value, window[63:8]};
			if (phase == htff_pkg::PH_HEAD) begin
				if (byte_pos + 1 >= hl && window_hit(head_pat, hl)) begin
					head_start = byte_pos + 1 - hl;
					after_head = 0;
					phase = htff_pkg::PH_TAIL;
				end
			end else if (phase == htff_pkg::PH_TAIL) begin
				if (after_head < htff_pkg::MAX_FRAME) after_head++;
				// The tail has to start after the last head byte.
				if (after_head >= tl && window_hit(tail_pat, tl)) begin
					span = after_head + hl;
					if (span > htff_pkg::MAX_FRAME) span = htff_pkg::MAX_FRAME;
					r.found = 1'b1;
					r.match_start = head_start[htff_pkg::IDX_W-1:0];
					r.match_length = span[htff_pkg::LEN_W-1:0];
					hit = 1'b1;
					phase = htff_pkg::PH_DONE;
				end
			end
			if (byte_pos < htff_pkg::MAX_FRAME - 1) byte_pos++;
			if (hit) begin
				expected_q.push_back(r);
			end else if (is_last && phase != htff_pkg::PH_DONE) begin
				expected_q.push_back('0);
			end
			if (is_last) clear_frame();
		endfunction

		function void check_result(htff_pkg::result_t got);
			htff_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected: found %0d start %0d length %0d",
					$time, got.found, got.match_start, got.match_length);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d, got %0d", $time, want.found, got.found);
				errors++;
			end
			if (got.match_start !== want.match_start) begin
				$display("%0t: match_start expected %0d, got %0d", $time,
					want.match_start, got.match_start);
				errors++;
			end
			if (got.match_length !== want.match_length) begin
				$display("%0t: match_length expected %0d, got %0d", $time,
					want.match_length, got.match_length);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [htff_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [htff_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [7:0]                      s_tdata;   // [7:0] in_byte
	logic                            s_tlast;   // frame_end
	logic                            m_tvalid;
	logic                            m_tready;
	logic [23:0]                     m_tdata;   // [9:0] match_start, [20:10] match_length
	logic                            m_tuser;   // found

	frame_search_sb sb = new();

	int          src_idle_pct;
	int          snk_idle_pct;
	bit          hold_req;
	int          cycle_count;
	int unsigned cur_hl;
	int unsigned cur_tl;
	logic [63:0] cur_hpat;
	logic [63:0] cur_tpat;
	logic [8:0]  warmup[$];

	head_tail_frame_finder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever @(posedge clk) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever @(negedge clk) begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		htff_pkg::result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tuser;
			got.match_start = m_tdata[9:0];
			got.match_length = m_tdata[20:10];
			sb.check_result(got);
		end
	end

	// All tasks start and end at a falling edge.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(value, is_last);
		@(negedge clk);
	endtask

	// Random bytes with the head and tail patterns laid over them; a negative
	// position leaves that pattern out.
	task automatic send_frame(input int n, input int head_at, input int tail_at);
		logic [7:0] frame_bytes[$];
		for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
		if (head_at >= 0) begin
			for (int i = 0; i < cur_hl; i++) frame_bytes[head_at + i] = cur_hpat[8*i +: 8];
		end
		if (tail_at >= 0) begin
			for (int i = 0; i < cur_tl; i++) frame_bytes[tail_at + i] = cur_tpat[8*i +: 8];
		end
		for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
	endtask

	task automatic load_config(input logic [63:0] hp, input logic [3:0] hl,
			input logic [63:0] tp, input logic [3:0] tl);
		cfg_we <= 1'b1;
		cfg_index <= htff_pkg::REG_HEAD_PATTERN;
		cfg_data <= hp;
		@(negedge clk);
		cfg_index <= htff_pkg::REG_HEAD_LENGTH;
		cfg_data <= 64'(hl);
		@(negedge clk);
		cfg_index <= htff_pkg::REG_TAIL_PATTERN;
		cfg_data <= tp;
		@(negedge clk);
		cfg_index <= htff_pkg::REG_TAIL_LENGTH;
		cfg_data <= 64'(tl);
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_config(hp, hl, tp, tl);
		cur_hpat = hp;
		cur_tpat = tp;
		cur_hl = sb.usable_len(hl);
		cur_tl = sb.usable_len(tl);
	endtask

	// Bytes after a match make no result, so let the block run on past the
	// last result before touching the registers. The last byte sent must
	// not stay on offer while waiting.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int          kind;
		int          n;
		int          p;
		int          q;
		int          span;
		int          seg_bytes;
		int          s;
		logic [3:0]  hl;
		logic [3:0]  tl;
		logic [63:0] hp;
		logic [63:0] tp;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		hold_req = 1'b0;
		src_idle_pct = 6;
		snk_idle_pct = 59;
		cur_hpat = '0;
		cur_tpat = '0;
		cur_hl = 1;
		cur_tl = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset patterns are a single zero byte for both head and tail:
		// lone head, head then tail, ignored bytes after a match, no match,
		// and a match on the last byte.
		warmup = '{9'h100,
			9'h000, 9'h100,
			9'h0FF, 9'h000, 9'h0FF, 9'h000, 9'h1FF,
			9'h0FF, 9'h0FF, 9'h001, 9'h180,
			9'h07F, 9'h000, 9'h000, 9'h0AA, 9'h155,
			9'h000, 9'h0FE, 9'h100};
		foreach (warmup[i]) send_byte(warmup[i][7:0], warmup[i][8]);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 6;
					snk_idle_pct = 59;
				end
				1: begin
					src_idle_pct = 59;
					snk_idle_pct = 6;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				s = ph * 4 + seg;
				wait_idle();
				hp = {$urandom, $urandom};
				tp = {$urandom, $urandom};
				hl = 4'($urandom_range(1, 8));
				tl = 4'($urandom_range(1, 8));
				// The first settings walk the length extremes, including the
				// codes outside the legal range.
				case (s)
					0: begin
						hl = 4'd1;
						tl = 4'd8;
						hp = '0;
						tp = '1;
					end
					1: begin
						hl = 4'd8;
						tl = 4'd1;
						hp = '1;
						tp = '0;
					end
					2: begin
						hl = 4'd0;
						tl = 4'd15;
					end
					3: begin
						hl = 4'd15;
						tl = 4'd0;
					end
					6: begin
						hl = 4'd8;
						tl = 4'd8;
					end
					default: ;
				endcase
				load_config(hp, hl, tp, tl);
				span = cur_hl + cur_tl;
				if (s == 6) begin
					// Head near the start and tail at the very end: the index,
					// the byte count after the head and the length saturate.
					n = htff_pkg::MAX_FRAME + 16 + $urandom_range(0, 8);
					send_frame(n, $urandom_range(0, 3), n - cur_tl);
				end
				if (ph == 2 && seg == 0) hold_req = 1'b1;
				seg_bytes = 0;
				while (seg_bytes < SEG_BYTES) begin
					kind = $urandom_range(9);
					if (kind <= 6) begin
						n = span + $urandom_range(0, 24);
						p = $urandom_range(0, n - span);
						q = p + cur_hl + $urandom_range(0, n - span - p);
						send_frame(n, p, q);
					end else if (kind == 7) begin
						n = cur_hl + $urandom_range(0, 20);
						send_frame(n, $urandom_range(0, n - cur_hl), -1);
					end else if (kind == 8) begin
						n = span + $urandom_range(0, 20);
						q = $urandom_range(0, n - span);
						p = q + cur_tl + $urandom_range(0, n - span - q);
						send_frame(n, p, q);
					end else begin
						n = $urandom_range(1, 24);
						send_frame(n, -1, -1);
					end
					seg_bytes += n;
				end
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
